>>> src/crc8_checked_sensor_frame_receiver_top_macros.svh
`ifndef CRC8_CHECKED_SENSOR_FRAME_RECEIVER_TOP_MACROS_SVH
`define CRC8_CHECKED_SENSOR_FRAME_RECEIVER_TOP_MACROS_SVH

// invariant checked on every clock outside reset
`define CRC8R_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cause in one cycle, effect in the next
`define CRC8R_IMPLIES(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

>>> src/crc8r_pkg.sv
package crc8r_pkg;

  localparam int ADDR_W = 5;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SENSOR_ID     = 3'd0;
  localparam reg_idx_t REG_TIMEOUT_TICKS = 3'd1;
  localparam reg_idx_t REG_BYTE_GAP      = 3'd2;
  localparam reg_idx_t REG_START_GAP     = 3'd3;
  localparam reg_idx_t REG_MAX_TICKS     = 3'd4;
  localparam reg_idx_t REG_GAP_CHECK     = 3'd5;

  localparam logic [3:0]  RST_SENSOR_ID     = 4'd0;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd200;
  localparam logic [15:0] RST_BYTE_GAP      = 16'd1;
  localparam logic [15:0] RST_START_GAP     = 16'd3;
  localparam logic [15:0] RST_MAX_TICKS     = 16'd1000;
  localparam logic        RST_GAP_CHECK     = 1'b1;

  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;
  localparam logic [1:0] MODE_TAKE    = 2'd3;

  typedef logic [3:0] phase_t;
  localparam phase_t PH_IDLE      = 4'd0;
  localparam phase_t PH_FIRST_DAT = 4'd1;
  localparam phase_t PH_LAST_DAT  = 4'd12;
  localparam phase_t PH_CRC       = 4'd13;
  localparam phase_t PH_HELD      = 4'd14;

  localparam int FRAME_DEPTH = 13;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam int REQ_TIMER_LOAD = 100;

  typedef struct packed {
    logic [3:0]  sensor_id;
    logic [15:0] timeout_ticks;
    logic [15:0] byte_gap_ticks;
    logic [15:0] start_gap_ticks;
    logic [15:0] max_ticks;
    logic        gap_check_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_ready;
    logic        crc_bad;
    logic        timed_out;
    logic        waiting;
    logic        busy_res;
    logic [7:0]  id_code;
    logic [15:0] current_raw;
    logic [15:0] charge_raw;
    logic [15:0] voltage_raw;
    logic [15:0] temp_one_raw;
    logic [15:0] temp_two_raw;
    logic [15:0] temp_three_raw;
  } out_item_t;

  // dallas/maxim crc-8, reflected, one byte
  function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/crc8r_regs.sv
module crc8r_regs
  import crc8r_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_id        <= RST_SENSOR_ID;
      cfg.timeout_ticks    <= RST_TIMEOUT_TICKS;
      cfg.byte_gap_ticks   <= RST_BYTE_GAP;
      cfg.start_gap_ticks  <= RST_START_GAP;
      cfg.max_ticks        <= RST_MAX_TICKS;
      cfg.gap_check_enable <= RST_GAP_CHECK;
    end else if (wr_en) begin
      unique case (idx)
        REG_SENSOR_ID:     cfg.sensor_id        <= pwdata[3:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks    <= pwdata[15:0];
        REG_BYTE_GAP:      cfg.byte_gap_ticks   <= pwdata[15:0];
        REG_START_GAP:     cfg.start_gap_ticks  <= pwdata[15:0];
        REG_MAX_TICKS:     cfg.max_ticks        <= pwdata[15:0];
        REG_GAP_CHECK:     cfg.gap_check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SENSOR_ID:     prdata = 32'(cfg.sensor_id);
      REG_TIMEOUT_TICKS: prdata = 32'(cfg.timeout_ticks);
      REG_BYTE_GAP:      prdata = 32'(cfg.byte_gap_ticks);
      REG_START_GAP:     prdata = 32'(cfg.start_gap_ticks);
      REG_MAX_TICKS:     prdata = 32'(cfg.max_ticks);
      REG_GAP_CHECK:     prdata = 32'(cfg.gap_check_enable);
      default:           prdata = '0;
    endcase
  end

endmodule

>>> src/crc8r_core.sv
`include "crc8_checked_sensor_frame_receiver_top_macros.svh"

module crc8r_core
  import crc8r_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      step_en,
  input  in_item_t  item,
  output out_item_t res
);

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  phase_t                rx_phase, rx_phase_next;
  logic [7:0]            crc_residue, crc_residue_next;
  logic [TIMER_BITS-1:0] gap_timer, gap_timer_next;
  logic                  waiting_flag, waiting_flag_next;
  logic                  busy_flag, busy_flag_next;
  logic [7:0]            frame_bytes [FRAME_DEPTH];

  logic       frame_wr;
  logic [3:0] frame_idx;
  logic       crc_bad, timed_out;
  logic       early, late;
  logic [CW-1:0] timer_x, start_x, byte_gap_x, timeout_x;
  logic [CW:0]   tick_sum, tick_max, tick_sat, timer_mask;

  assign timer_x    = CW'(gap_timer);
  assign start_x    = CW'(cfg.start_gap_ticks);
  assign byte_gap_x = CW'(cfg.byte_gap_ticks);
  assign timeout_x  = CW'(cfg.timeout_ticks);
  assign timer_mask = (CW + 1)'({TIMER_BITS{1'b1}});
  assign early      = cfg.gap_check_enable && (timer_x < start_x);
  assign late       = cfg.gap_check_enable && (timer_x > byte_gap_x);

  // saturating tick
  always_comb begin
    tick_sum = {1'b0, timer_x} + (CW + 1)'(1);
    tick_max = (CW + 1)'(cfg.max_ticks);
    tick_sat = (tick_sum > tick_max) ? tick_max : tick_sum;
    if (tick_sat > timer_mask) begin
      tick_sat = timer_mask;
    end
  end

  always_comb begin
    rx_phase_next     = rx_phase;
    crc_residue_next  = crc_residue;
    gap_timer_next    = gap_timer;
    waiting_flag_next = waiting_flag;
    busy_flag_next    = busy_flag;
    frame_wr          = 1'b0;
    frame_idx         = rx_phase;
    crc_bad           = 1'b0;
    timed_out         = 1'b0;
    unique case (item.mode)
      MODE_BYTE: begin
        crc_residue_next = crc_step(crc_residue, item.rx_byte);
        if (rx_phase == PH_IDLE) begin
          if (!early && (item.rx_byte[7:4] == cfg.sensor_id)) begin
            crc_residue_next  = crc_step(CRC_INIT, item.rx_byte);
            frame_wr          = 1'b1;
            frame_idx         = PH_IDLE;
            rx_phase_next     = PH_FIRST_DAT;
            waiting_flag_next = 1'b0;
          end
        end else if (late) begin
          rx_phase_next = PH_IDLE;
        end else if (rx_phase >= PH_FIRST_DAT && rx_phase <= PH_LAST_DAT) begin
          frame_wr      = 1'b1;
          rx_phase_next = rx_phase + 4'd1;
        end else if (rx_phase == PH_CRC) begin
          if (crc_residue_next == 8'd0) begin
            rx_phase_next = PH_HELD;
          end else begin
            rx_phase_next = PH_IDLE;
            crc_bad       = 1'b1;
          end
        end else if (rx_phase != PH_HELD) begin
          rx_phase_next = PH_IDLE;
        end
        if (cfg.gap_check_enable) begin
          gap_timer_next = '0;
        end
      end
      MODE_TICK: begin
        gap_timer_next = tick_sat[TIMER_BITS-1:0];
        if ((waiting_flag || rx_phase != PH_IDLE) && (tick_sat > (CW + 1)'(timeout_x))) begin
          rx_phase_next     = PH_IDLE;
          waiting_flag_next = 1'b0;
          busy_flag_next    = 1'b0;
          timed_out         = 1'b1;
        end
      end
      MODE_REQUEST: begin
        busy_flag_next    = 1'b1;
        waiting_flag_next = 1'b1;
        gap_timer_next    = TIMER_BITS'(REQ_TIMER_LOAD);
      end
      MODE_TAKE: begin
        rx_phase_next = PH_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase     <= PH_IDLE;
      crc_residue  <= '0;
      gap_timer    <= '0;
      waiting_flag <= 1'b0;
      busy_flag    <= 1'b0;
    end else if (step_en) begin
      rx_phase     <= rx_phase_next;
      crc_residue  <= crc_residue_next;
      gap_timer    <= gap_timer_next;
      waiting_flag <= waiting_flag_next;
      busy_flag    <= busy_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && frame_wr) begin
      frame_bytes[frame_idx] <= item.rx_byte;
    end
  end

  always_comb begin
    res             = '0;
    res.frame_ready = (rx_phase_next == PH_HELD);
    res.crc_bad     = crc_bad;
    res.timed_out   = timed_out;
    res.waiting     = waiting_flag_next;
    res.busy_res    = busy_flag_next;
    if (rx_phase_next == PH_HELD) begin
      res.id_code        = frame_bytes[0];
      res.current_raw    = {frame_bytes[2], frame_bytes[1]};
      res.charge_raw     = {frame_bytes[4], frame_bytes[3]};
      res.voltage_raw    = {frame_bytes[6], frame_bytes[5]};
      res.temp_one_raw   = {frame_bytes[8], frame_bytes[7]};
      res.temp_two_raw   = {frame_bytes[10], frame_bytes[9]};
      res.temp_three_raw = {frame_bytes[12], frame_bytes[11]};
    end
  end

  `CRC8R_HOLDS(a_phase_legal, rx_phase <= PH_HELD, "receive phase out of range")
  `CRC8R_HOLDS(a_wait_busy, !waiting_flag || busy_flag, "waiting without busy")
  `CRC8R_HOLDS(a_one_fault, !(step_en && res.crc_bad && res.timed_out), "two faults at once")
  `CRC8R_IMPLIES(a_timeout_clears, step_en && res.timed_out,
                 rx_phase == PH_IDLE && !waiting_flag && !busy_flag, "timeout left state")

endmodule

>>> src/crc8_checked_sensor_frame_receiver_top.sv
// channel  | signals                                 | dir | payload
// item     | item_valid, item_stall, item            | in  | in_item_t
// result   | result_valid, result_stall, result      | out | out_item_t
// apb cfg  | psel penable pwrite paddr pwdata prdata | in  | six registers at 4*i
//
// one item per cycle unless result stalls; input register, then result register
// the rate is set by the state update between the input and result registers
// rst is synchronous: phase idle, flags, residue and timer zero, registers at defaults
// a stalled result holds the update; one more item waits in the input register
module crc8_checked_sensor_frame_receiver_top
  import crc8r_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  in_item_t          item,
  output logic              result_valid,
  input  logic              result_stall,
  output out_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t      cfg;
  logic      stage_valid;
  in_item_t  stage_item;
  logic      advance;
  logic      step_en;
  out_item_t core_res;

  assign advance    = !result_valid || !result_stall;
  assign step_en    = stage_valid && advance;
  assign item_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result <= core_res;
    end
  end

  crc8r_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crc8r_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (step_en),
    .item    (stage_item),
    .res     (core_res)
  );

endmodule

>>> test/tb_crc8_checked_sensor_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_crc8_checked_sensor_frame_receiver_top;
  import crc8r_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  in_item_t          item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  out_item_t         result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  crc8_checked_sensor_frame_receiver_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver copy kept in step with accepted transfers
  cfg_t       rx_cfg = '{RST_SENSOR_ID, RST_TIMEOUT_TICKS, RST_BYTE_GAP, RST_START_GAP,
                         RST_MAX_TICKS, RST_GAP_CHECK};
  phase_t     rx_phase = PH_IDLE;
  logic [7:0] rx_residue = 8'h00;
  logic [15:0] rx_timer = 16'h0000;
  logic       rx_waiting = 1'b0;
  logic       rx_busy = 1'b0;
  logic [7:0] frame_buf [FRAME_DEPTH] = '{default: 8'h00};

  in_item_t   pending_items [$];
  out_item_t  expected_status [$];
  int         queued = 0;
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic       item_moved = 1'b0;

  // lsb-first bit-serial form of the 0x8c reflected crc-8
  function automatic logic [7:0] crc8_byte(logic [7:0] r, logic [7:0] d);
    logic [7:0] acc;
    logic       fb;
    acc = r;
    for (int i = 0; i < 8; i++) begin
      fb = acc[0] ^ d[i];
      acc = {1'b0, acc[7:1]};
      if (fb) acc = acc ^ 8'h8C;
    end
    return acc;
  endfunction

  function automatic out_item_t advance_receiver(in_item_t it);
    out_item_t  r;
    logic [16:0] t;
    logic       early;
    r = '0;
    case (it.mode)
      MODE_BYTE: begin
        rx_residue = crc8_byte(rx_residue, it.rx_byte);
        if (rx_phase == PH_IDLE) begin
          early = rx_cfg.gap_check_enable && (rx_timer < rx_cfg.start_gap_ticks);
          if (!early && it.rx_byte[7:4] == rx_cfg.sensor_id) begin
            rx_residue = crc8_byte(CRC_INIT, it.rx_byte);
            frame_buf[0] = it.rx_byte;
            rx_phase = PH_FIRST_DAT;
            rx_waiting = 1'b0;
          end
        end else if (rx_cfg.gap_check_enable && rx_timer > rx_cfg.byte_gap_ticks) begin
          rx_phase = PH_IDLE;
        end else if (rx_phase <= PH_LAST_DAT) begin
          frame_buf[rx_phase] = it.rx_byte;
          rx_phase = rx_phase + 1'b1;
        end else if (rx_phase == PH_CRC) begin
          if (rx_residue == 8'h00) begin
            rx_phase = PH_HELD;
          end else begin
            rx_phase = PH_IDLE;
            r.crc_bad = 1'b1;
          end
        end else if (rx_phase != PH_HELD) begin
          rx_phase = PH_IDLE;
        end
        if (rx_cfg.gap_check_enable) rx_timer = '0;
      end
      MODE_TICK: begin
        t = {1'b0, rx_timer} + 17'd1;
        if (t > {1'b0, rx_cfg.max_ticks}) t = {1'b0, rx_cfg.max_ticks};
        rx_timer = t[15:0];
        if ((rx_waiting || rx_phase != PH_IDLE) && rx_timer > rx_cfg.timeout_ticks) begin
          rx_phase = PH_IDLE;
          rx_waiting = 1'b0;
          rx_busy = 1'b0;
          r.timed_out = 1'b1;
        end
      end
      MODE_REQUEST: begin
        rx_busy = 1'b1;
        rx_waiting = 1'b1;
        rx_timer = 16'(REQ_TIMER_LOAD);
      end
      default: rx_phase = PH_IDLE;
    endcase
    r.waiting = rx_waiting;
    r.busy_res = rx_busy;
    if (rx_phase == PH_HELD) begin
      r.frame_ready = 1'b1;
      r.id_code = frame_buf[0];
      r.current_raw = {frame_buf[2], frame_buf[1]};
      r.charge_raw = {frame_buf[4], frame_buf[3]};
      r.voltage_raw = {frame_buf[6], frame_buf[5]};
      r.temp_one_raw = {frame_buf[8], frame_buf[7]};
      r.temp_two_raw = {frame_buf[10], frame_buf[9]};
      r.temp_three_raw = {frame_buf[12], frame_buf[11]};
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (mismatches < 10) $display("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(out_item_t want, out_item_t got);
    check_field("frame_ready", want.frame_ready, got.frame_ready);
    check_field("crc_bad", want.crc_bad, got.crc_bad);
    check_field("timed_out", want.timed_out, got.timed_out);
    check_field("waiting", want.waiting, got.waiting);
    check_field("busy_res", want.busy_res, got.busy_res);
    check_field("id_code", want.id_code, got.id_code);
    check_field("current_raw", want.current_raw, got.current_raw);
    check_field("charge_raw", want.charge_raw, got.charge_raw);
    check_field("voltage_raw", want.voltage_raw, got.voltage_raw);
    check_field("temp_one_raw", want.temp_one_raw, got.temp_one_raw);
    check_field("temp_two_raw", want.temp_two_raw, got.temp_two_raw);
    check_field("temp_three_raw", want.temp_three_raw, got.temp_three_raw);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_moved <= 1'b0;
    end else begin
      item_moved <= item_valid && !item_stall;
      if (result_valid && !result_stall) begin
        if (expected_status.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer: got %h", result);
          mismatches++;
        end else begin
          compare_result(expected_status.pop_front(), result);
        end
      end
      if (item_valid && !item_stall) expected_status.push_back(advance_receiver(item));
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_moved) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item_valid <= 1'b1;
        item <= pending_items.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
    end
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  task automatic push_item(logic [1:0] mode, logic [7:0] b);
    in_item_t it;
    it.mode = mode;
    it.rx_byte = b;
    pending_items.push_back(it);
    queued++;
  endtask

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++) push_item(MODE_TICK, 8'($urandom_range(255)));
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_SENSOR_ID:     rx_cfg.sensor_id = val[3:0];
      REG_TIMEOUT_TICKS: rx_cfg.timeout_ticks = val[15:0];
      REG_BYTE_GAP:      rx_cfg.byte_gap_ticks = val[15:0];
      REG_START_GAP:     rx_cfg.start_gap_ticks = val[15:0];
      REG_MAX_TICKS:     rx_cfg.max_ticks = val[15:0];
      REG_GAP_CHECK:     rx_cfg.gap_check_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int sid, int tmo, int bgap, int sgap, int maxt, int gce);
    write_reg(REG_SENSOR_ID, sid);
    write_reg(REG_TIMEOUT_TICKS, tmo);
    write_reg(REG_BYTE_GAP, bgap);
    write_reg(REG_START_GAP, sgap);
    write_reg(REG_MAX_TICKS, maxt);
    write_reg(REG_GAP_CHECK, gce);
  endtask

  // body_len counts bytes after the identifier, 13 includes the crc byte
  task automatic queue_frame(bit extremes, bit bad_crc, int late_at, int body_len);
    logic [7:0] crc;
    logic [7:0] b;
    int         n;
    int         bgap;
    bgap = (rx_cfg.byte_gap_ticks > 2) ? 2 : rx_cfg.byte_gap_ticks;
    if (!extremes && $urandom_range(3) == 0) push_item(MODE_REQUEST, 8'($urandom_range(255)));
    if (rx_cfg.gap_check_enable) begin
      n = (rx_cfg.start_gap_ticks > 40) ? 40 : rx_cfg.start_gap_ticks;
      push_ticks(n + (extremes ? 0 : $urandom_range(2)));
    end else begin
      push_ticks($urandom_range(2));
    end
    b = {rx_cfg.sensor_id, 4'($urandom_range(15))};
    crc = crc8_byte(CRC_INIT, b);
    push_item(MODE_BYTE, b);
    for (int k = 1; k <= body_len; k++) begin
      if (k == late_at) begin
        push_ticks(rx_cfg.byte_gap_ticks + 1 + $urandom_range(1));
      end else if (!extremes) begin
        if (rx_cfg.gap_check_enable) begin
          if ($urandom_range(1) == 0) push_ticks($urandom_range(bgap));
        end else if ($urandom_range(3) == 0) begin
          push_ticks(1);
        end
      end
      if (k <= 12) begin
        if (extremes) b = k[0] ? 8'hFF : 8'h00;
        else if ($urandom_range(7) == 0) b = $urandom_range(1) ? 8'hFF : 8'h00;
        else b = 8'($urandom_range(255));
        crc = crc8_byte(crc, b);
      end else begin
        b = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
      end
      push_item(MODE_BYTE, b);
    end
  endtask

  task automatic random_traffic(int target);
    int start;
    int pick;
    int n;
    start = queued;
    while (queued - start < target) begin
      pick = $urandom_range(99);
      n = rx_cfg.timeout_ticks + 3;
      if (rx_cfg.timeout_ticks >= 100) n = n - 100;
      if (n > 60) n = 60;
      if (pick < 55) begin
        queue_frame(1'b0, $urandom_range(6) == 0, 0, 13);
        pick = $urandom_range(9);
        if (pick < 5) push_item(MODE_TAKE, 8'($urandom_range(255)));
        else if (pick < 7) push_item(MODE_BYTE, 8'($urandom_range(255)));
      end else if (pick < 65) begin
        if (rx_cfg.gap_check_enable && rx_cfg.byte_gap_ticks <= 20)
          queue_frame(1'b0, 1'b0, $urandom_range(1, 13), 13);
        else
          queue_frame(1'b0, 1'b0, 0, $urandom_range(13));
      end else if (pick < 72) begin
        queue_frame(1'b0, 1'b0, 0, $urandom_range(12));
        push_ticks($urandom_range(1, n));
      end else if (pick < 80) begin
        push_item(MODE_REQUEST, 8'($urandom_range(255)));
        push_ticks($urandom_range(1, n));
      end else begin
        repeat ($urandom_range(1, 6))
          push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: early id byte, clean frame, byte while held, take, request, foreign id
    push_item(MODE_BYTE, 8'h00);
    queue_frame(1'b1, 1'b0, 0, 13);
    push_item(MODE_BYTE, 8'hAA);
    push_item(MODE_TAKE, 8'hFF);
    push_item(MODE_REQUEST, 8'h5A);
    push_item(MODE_BYTE, 8'hF3);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(3, 150, 1, 3, 1000, 1);
        1: set_config(15, 5, 0, 0, 8, 1);
        2: set_config(10, 65535, 65535, 65535, 65535, 0);
        3: set_config(0, 0, 0, 0, 0, 1);
        default: set_config($urandom_range(15), $urandom_range(3, 40), $urandom_range(3),
                            $urandom_range(4), $urandom_range(5, 60), p != 6);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      random_traffic(195);
      drain();
    end

    if (expected_status.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/crc8r_pkg.sv
src/crc8r_regs.sv
src/crc8r_core.sv
src/crc8_checked_sensor_frame_receiver_top.sv
test/tb_crc8_checked_sensor_frame_receiver_top.sv
